// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define DSD_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition");
`else
`define DSD_ASSERT(lbl, clk, rstn, prop)
`define DSD_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hw/rtl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the area-average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_HEIGHT   = 4096;
	localparam int SUM_BITS     = 32;
	localparam int DIM_BITS     = 13;
	localparam int IDX_BITS     = $clog2(MAX_WIDTH);
	localparam int CNT_BITS     = 2 * DIM_BITS;
	localparam int QUO_BITS     = 8;
	localparam int DEN_BITS     = CNT_BITS + QUO_BITS - 1;
	localparam int DIV_BITS     = (DEN_BITS > SUM_BITS ? DEN_BITS : SUM_BITS) + 1;
	localparam int QDEPTH       = 4;
	localparam int QPTR_BITS    = $clog2(QDEPTH);
	localparam int CFG_IDX_BITS = 8;
	localparam int STEP_BITS    = $clog2(DIM_BITS);

	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = CFG_IDX_BITS'(3);

	typedef struct packed {
		logic [7:0] in_alpha;
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_last;
	} pix_out_t;

	typedef logic [3:0][SUM_BITS-1:0] sums_t;

	// one finished column band of one source row
	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		sums_t               sums;
		logic                first;
		logic                emit;
		logic                last;
		logic [CNT_BITS-1:0] count;
	} col_job_t;

	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [QPTR_BITS:0]   count;
	} q_stat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_ACC,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dsd_queue.sv
// ----------------------------------------------------------------------------
// dsd_queue
// Short queue of column-band words between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire dsd_pkg::col_job_t wr_job,
	input  wire logic              rd_en,
	output dsd_pkg::col_job_t      rd_job,
	output dsd_pkg::q_stat_t       stat
);
	import dsd_pkg::*;

	col_job_t             slot_q [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && !stat.empty;

	always_comb begin
		stat.full  = (count_q == (QPTR_BITS+1)'(QDEPTH));
		stat.empty = (count_q == '0);
		stat.count = count_q;
	end

	assign rd_job = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wptr_q] <= wr_job;
	end

endmodule

`default_nettype wire

// File: hw/rtl/dsd_front.sv
// ----------------------------------------------------------------------------
// dsd_front
// Configuration, band bookkeeping and per-row run sums of source pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire dsd_pkg::pix_in_t                     src_pix,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [dsd_pkg::DIM_BITS-1:0]         cfg_data,
	output logic                                      q_push,
	output dsd_pkg::col_job_t                         q_job,
	input  wire logic                                 q_full
);
	import dsd_pkg::*;

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
			input logic [DIM_BITS-1:0] hi);
		logic [DIM_BITS-1:0] r;
		r = v;
		if (v == '0) r = DIM_BITS'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

	logic [DIM_BITS-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [DIM_BITS-1:0] eff_w, eff_h, eff_tw, eff_th;

	// setup divider: source size over target size, both axes at once
	logic                 busy_q;
	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] bsel;
	logic [DIM_BITS:0]    wt, ht;
	logic [DIM_BITS-1:0]  wrem_q, hrem_q, wquo_q, hquo_q;
	logic [DIM_BITS-1:0]  wrem_nx, hrem_nx, wquo_nx, hquo_nx;

	logic [DIM_BITS-1:0] col_a_q, col_b_q, row_a_q, row_b_q;

	logic [DIM_BITS-1:0] src_col_q, src_row_q, tc_q, tr_q;
	logic [DIM_BITS-1:0] col_start_q, col_end_q, col_r_q;
	logic [DIM_BITS-1:0] row_start_q, row_end_q, row_r_q;
	sums_t               run_q;
	sums_t               run_new;
	logic [3:0][7:0]     pix;

	logic                accept;
	logic                col_hit, row_hit, col_wrap_pix, frame_end;
	logic                col_more, row_more;
	logic [DIM_BITS:0]   col_rs, row_rs;
	logic                col_cy, row_cy;
	logic [DIM_BITS-1:0] col_end_adv, col_r_adv, row_end_adv, row_r_adv;

	assign eff_w  = clamp_dim(src_w_q, DIM_BITS'(MAX_WIDTH));
	assign eff_h  = clamp_dim(src_h_q, DIM_BITS'(MAX_HEIGHT));
	assign eff_tw = clamp_dim(dst_w_q, eff_w);
	assign eff_th = clamp_dim(dst_h_q, eff_h);

	assign cfg_ready = !busy_q;
	assign full      = busy_q || q_full;
	assign accept    = push && !full;

	always_comb begin
		bsel    = STEP_BITS'(DIM_BITS - 1) - step_q;
		wt      = {wrem_q, eff_w[bsel]};
		ht      = {hrem_q, eff_h[bsel]};
		wrem_nx = wt[DIM_BITS-1:0];
		hrem_nx = ht[DIM_BITS-1:0];
		wquo_nx = {wquo_q[DIM_BITS-2:0], 1'b0};
		hquo_nx = {hquo_q[DIM_BITS-2:0], 1'b0};
		if (wt >= {1'b0, eff_tw}) begin
			wrem_nx    = DIM_BITS'(wt - {1'b0, eff_tw});
			wquo_nx[0] = 1'b1;
		end
		if (ht >= {1'b0, eff_th}) begin
			hrem_nx    = DIM_BITS'(ht - {1'b0, eff_th});
			hquo_nx[0] = 1'b1;
		end
	end

	assign pix = {src_pix.in_alpha, src_pix.in_blue, src_pix.in_green, src_pix.in_red};

	always_comb begin
		for (int c = 0; c < 4; c++) run_new[c] = run_q[c] + SUM_BITS'(pix[c]);
	end

	// next band ends by stepping quotient and remainder
	always_comb begin
		col_rs      = {1'b0, col_r_q} + {1'b0, col_b_q};
		col_cy      = col_rs >= {1'b0, eff_tw};
		col_r_adv   = col_cy ? DIM_BITS'(col_rs - {1'b0, eff_tw}) : col_rs[DIM_BITS-1:0];
		col_end_adv = col_end_q + col_a_q + DIM_BITS'(col_cy);
		row_rs      = {1'b0, row_r_q} + {1'b0, row_b_q};
		row_cy      = row_rs >= {1'b0, eff_th};
		row_r_adv   = row_cy ? DIM_BITS'(row_rs - {1'b0, eff_th}) : row_rs[DIM_BITS-1:0];
		row_end_adv = row_end_q + row_a_q + DIM_BITS'(row_cy);
	end

	assign col_hit      = (src_col_q + 1'b1) == col_end_q;
	assign row_hit      = (src_row_q + 1'b1) == row_end_q;
	assign col_wrap_pix = (src_col_q + 1'b1) == eff_w;
	assign frame_end    = (src_row_q + 1'b1) == eff_h;
	assign col_more     = (tc_q + 1'b1) < eff_tw;
	assign row_more     = (tr_q + 1'b1) < eff_th;

	assign q_push = accept && col_hit;
	always_comb begin
		q_job.idx   = tc_q[IDX_BITS-1:0];
		q_job.sums  = run_new;
		q_job.first = (src_row_q == row_start_q);
		q_job.emit  = row_hit;
		q_job.last  = col_wrap_pix && frame_end;
		q_job.count = (col_end_q - col_start_q) * (row_end_q - row_start_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= DIM_BITS'(1024);
			src_h_q     <= DIM_BITS'(1024);
			dst_w_q     <= DIM_BITS'(256);
			dst_h_q     <= DIM_BITS'(256);
			busy_q      <= 1'b1;
			step_q      <= '0;
			wrem_q      <= '0;
			hrem_q      <= '0;
			wquo_q      <= '0;
			hquo_q      <= '0;
			col_a_q     <= '0;
			col_b_q     <= '0;
			row_a_q     <= '0;
			row_b_q     <= '0;
			src_col_q   <= '0;
			src_row_q   <= '0;
			tc_q        <= '0;
			tr_q        <= '0;
			col_start_q <= '0;
			col_end_q   <= '0;
			col_r_q     <= '0;
			row_start_q <= '0;
			row_end_q   <= '0;
			row_r_q     <= '0;
			run_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_w_q <= cfg_data;
				REG_SRC_HEIGHT: src_h_q <= cfg_data;
				REG_DST_WIDTH:  dst_w_q <= cfg_data;
				REG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index <= REG_DST_HEIGHT) begin
				busy_q <= 1'b1;
				step_q <= '0;
				wrem_q <= '0;
				hrem_q <= '0;
				wquo_q <= '0;
				hquo_q <= '0;
			end
		end else if (busy_q) begin
			wrem_q <= wrem_nx;
			hrem_q <= hrem_nx;
			wquo_q <= wquo_nx;
			hquo_q <= hquo_nx;
			step_q <= step_q + 1'b1;
			if (step_q == STEP_BITS'(DIM_BITS - 1)) begin
				// restart the frame with the fresh band steps
				busy_q      <= 1'b0;
				col_a_q     <= wquo_nx;
				col_b_q     <= wrem_nx;
				row_a_q     <= hquo_nx;
				row_b_q     <= hrem_nx;
				src_col_q   <= '0;
				src_row_q   <= '0;
				tc_q        <= '0;
				tr_q        <= '0;
				col_start_q <= '0;
				col_end_q   <= wquo_nx;
				col_r_q     <= wrem_nx;
				row_start_q <= '0;
				row_end_q   <= hquo_nx;
				row_r_q     <= hrem_nx;
				run_q       <= '0;
			end
		end else if (accept) begin
			if (col_wrap_pix) begin
				// last pixel of a row: rewind the column bands
				src_col_q   <= '0;
				tc_q        <= '0;
				col_start_q <= '0;
				col_end_q   <= col_a_q;
				col_r_q     <= col_b_q;
				run_q       <= '0;
				if (frame_end) begin
					src_row_q   <= '0;
					tr_q        <= '0;
					row_start_q <= '0;
					row_end_q   <= row_a_q;
					row_r_q     <= row_b_q;
				end else begin
					src_row_q <= src_row_q + 1'b1;
					if (row_hit) begin
						row_start_q <= row_end_q;
						tr_q        <= tr_q + 1'b1;
						if (row_more) begin
							row_end_q <= row_end_adv;
							row_r_q   <= row_r_adv;
						end
					end
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				if (col_hit) begin
					run_q       <= '0;
					col_start_q <= col_end_q;
					tc_q        <= tc_q + 1'b1;
					if (col_more) begin
						col_end_q <= col_end_adv;
						col_r_q   <= col_r_adv;
					end
				end else begin
					run_q <= run_new;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dsd_back.sv
// ----------------------------------------------------------------------------
// dsd_back
// Column-sum line store update, mean division and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dsd_pkg::q_stat_t   q_stat,
	output logic                    q_pop,
	input  wire dsd_pkg::col_job_t  q_job,
	output logic                    empty,
	input  wire logic               pop,
	output dsd_pkg::pix_out_t       dst_pix
);
	import dsd_pkg::*;

	back_state_t state_q, state_nx;

	sums_t               line_mem [MAX_WIDTH];
	sums_t               rd_s2;
	col_job_t            job_q;
	sums_t               acc_new;
	logic                mem_re, mem_we, div_init, div_run, opush;

	logic [3:0][SUM_BITS-1:0] rem_q;
	logic [3:0][QUO_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0]      den_q;
	logic [$clog2(QUO_BITS)-1:0] step_q;
	logic [3:0][DIV_BITS-1:0] trial;

	pix_out_t ofifo_q [2];
	logic     owp_q, orp_q;
	logic [1:0] ocnt_q;
	logic     ofull;

	assign ofull = ocnt_q == 2'd2;
	assign empty = ocnt_q == 2'd0;
	assign dst_pix = ofifo_q[orp_q];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc_new[c] = job_q.first ? job_q.sums[c] : rd_s2[c] + job_q.sums[c];
			trial[c]   = DIV_BITS'(rem_q[c]) - DIV_BITS'(den_q);
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: if (!q_stat.empty) state_nx = B_READ;
			B_READ: state_nx = B_ACC;
			B_ACC:  state_nx = job_q.emit ? B_DIV : B_IDLE;
			B_DIV:  if (step_q == '1) state_nx = B_OUT;
			B_OUT:  if (!ofull) state_nx = B_IDLE;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		div_init = 1'b0;
		div_run  = 1'b0;
		opush    = 1'b0;
		case (state_q)
			B_IDLE: q_pop = !q_stat.empty;
			B_READ: mem_re = 1'b1;
			B_ACC: begin
				mem_we   = 1'b1;
				div_init = job_q.emit;
			end
			B_DIV:  div_run = 1'b1;
			B_OUT:  opush = !ofull;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) line_mem[job_q.idx] <= acc_new;
		if (mem_re) rd_s2 <= line_mem[job_q.idx];
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_job;
		if (div_init) begin
			rem_q <= acc_new;
			quo_q <= '0;
			den_q <= DEN_BITS'(job_q.count) << (QUO_BITS - 1);
		end else if (div_run) begin
			// one quotient bit per cycle, all four channels at once
			for (int c = 0; c < 4; c++) begin
				if (!trial[c][DIV_BITS-1]) begin
					rem_q[c] <= trial[c][SUM_BITS-1:0];
					quo_q[c] <= {quo_q[c][QUO_BITS-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][QUO_BITS-2:0], 1'b0};
				end
			end
			den_q <= den_q >> 1;
		end
		if (opush) begin
			ofifo_q[owp_q] <= '{out_red: quo_q[0], out_green: quo_q[1],
				out_blue: quo_q[2], out_alpha: quo_q[3], frame_last: job_q.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (div_init) step_q <= '0;
			else if (div_run) step_q <= step_q + 1'b1;
			if (opush) owp_q <= !owp_q;
			if (pop && !empty) orp_q <= !orp_q;
			if (opush && !(pop && !empty)) ocnt_q <= ocnt_q + 1'b1;
			else if (!opush && pop && !empty) ocnt_q <= ocnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/box_filter_image_downscale_top.sv
// ----------------------------------------------------------------------------
// box_filter_image_downscale_top
// Area-average RGBA8 downscaler: front end tracks bands, back end averages.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  pixels    push / full        src_pix  (in_red, in_green, in_blue, in_alpha)
//  results   pop / empty        dst_pix  (out_red..out_alpha, frame_last)
//  config    cfg_valid/ready    cfg_index, cfg_data
//
//  The front end takes one pixel per clock while its 4-word queue has room.
//  Each column-band end passes the back end's line store read and add; when it
//  yields a target pixel it also passes the mean divider and the result queue.
//  After reset and after each register write the size divider runs with full
//  high and cfg_ready low; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module box_filter_image_downscale_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire dsd_pkg::pix_in_t                 src_pix,
	output logic                                  empty,
	input  wire logic                             pop,
	output dsd_pkg::pix_out_t                     dst_pix,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dsd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [dsd_pkg::DIM_BITS-1:0]     cfg_data
);
	import dsd_pkg::*;

	logic     q_push, q_pop;
	col_job_t q_wr_job, q_rd_job;
	q_stat_t  q_stat;

	dsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.src_pix   (src_pix),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_job     (q_wr_job),
		.q_full    (q_stat.full)
	);

	dsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_job (q_wr_job),
		.rd_en  (q_pop),
		.rd_job (q_rd_job),
		.stat   (q_stat)
	);

	dsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.q_pop   (q_pop),
		.q_job   (q_rd_job),
		.empty   (empty),
		.pop     (pop),
		.dst_pix (dst_pix)
	);

	`DSD_ASSERT(a_setup_blocks_input, clk, arst_n, !cfg_ready |-> full)
	`DSD_NEVER(a_queue_overrun, clk, arst_n, q_stat.count > (QPTR_BITS+1)'(QDEPTH))
	`DSD_NEVER(a_push_into_full_queue, clk, arst_n, q_push && q_stat.full)
	`DSD_NEVER(a_pop_from_empty_queue, clk, arst_n, q_pop && q_stat.empty)

endmodule

`default_nettype wire
